[hw/rtl/psrl_pkg.sv]
// -----------------------------------------------------------------------------
// Per-source rate limiter package
// Shared types, register map, verdict codes and defaults for the limiter.
// -----------------------------------------------------------------------------
package psrl_pkg;

   localparam int RATE_ENTRIES_DEF = 64;
   localparam int BAN_ENTRIES_DEF  = 64;

   // Slot indexes in the chains are carried at a fixed width of IDX_W = 12 bits.
   localparam int IDX_W = 12;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [15:0] MAX_PER_WINDOW_RST = 16'd60;
   localparam logic [11:0] WINDOW_SECONDS_RST = 12'd60;
   localparam logic [15:0] LOG_THRESHOLD_RST  = 16'd1000;
   localparam logic [31:0] EXEMPT_ADDR_RST    = 32'h7F00_0001;

   localparam logic [15:0] COUNT_MAX = 16'hFFFF;

   typedef enum logic [1:0] {
      REG_MAX_PER_WINDOW = 2'd0,
      REG_WINDOW_SECONDS = 2'd1,
      REG_LOG_THRESHOLD  = 2'd2,
      REG_EXEMPT_ADDR    = 2'd3
   } reg_index_type;

   typedef enum logic [2:0] {
      VERDICT_ACCEPT  = 3'd0,
      VERDICT_DROPPED = 3'd1,
      VERDICT_NEWBAN  = 3'd2,
      VERDICT_BANFULL = 3'd3,
      VERDICT_TABFULL = 3'd4
   } verdict_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BAN,
      ST_CSTART,
      ST_CNT,
      ST_FIN
   } state_type;

   // Word travelling along the ban chain.
   typedef struct packed {
      logic             tok;
      logic             hit;
      logic             free;
      logic [IDX_W-1:0] idx;
   } ban_link_type;

   // Word travelling along the counter chain.
   typedef struct packed {
      logic             tok;
      logic             hit;
      logic [15:0]      old;
      logic             free;
      logic [IDX_W-1:0] idx;
   } cnt_link_type;

   // Broadcast write into the ban chain.
   typedef struct packed {
      logic             add;
      logic [IDX_W-1:0] idx;
   } ban_cmd_type;

   // Broadcast commands into the counter chain.
   typedef struct packed {
      logic             clear;
      logic             alloc;
      logic [IDX_W-1:0] idx;
   } cnt_cmd_type;

endpackage

[hw/rtl/psrl_if.sv]
// -----------------------------------------------------------------------------
// Rate limiter channels
// Valid/ready channels for arriving messages and for verdict words.
// -----------------------------------------------------------------------------
interface psrl_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] src_addr;
   logic [31:0] now_seconds;

   modport source (output valid, output src_addr, output now_seconds, input ready);
   modport sink   (input valid, input src_addr, input now_seconds, output ready);
endinterface

interface psrl_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  verdict;
   logic        detail_flag;
   logic [15:0] source_count;

   modport source (output valid, output verdict, output detail_flag, output source_count,
                   input ready);
   modport sink   (input valid, input verdict, input detail_flag, input source_count,
                   output ready);
endinterface

[hw/rtl/psrl_ban_cell.sv]
// -----------------------------------------------------------------------------
// Ban list cell
// Holds one ban entry; checks the passing word for a match and a free slot.
// -----------------------------------------------------------------------------
module psrl_ban_cell #(
   parameter int IDX = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [31:0]            query_addr,
   input  psrl_pkg::ban_cmd_type  cmd,
   input  psrl_pkg::ban_link_type link_i,
   output psrl_pkg::ban_link_type link_o
);

   logic                   valid_ff, valid_in;
   logic [31:0]            addr_ff, addr_in;
   psrl_pkg::ban_link_type link_ff, link_in;

   always_comb begin
      link_in  = link_i;
      valid_in = valid_ff;
      addr_in  = addr_ff;
      if (link_i.tok && valid_ff && (addr_ff == query_addr)) begin
         link_in.hit = 1'b1;
      end
      if (link_i.tok && !link_i.free && !valid_ff) begin
         link_in.free = 1'b1;
         link_in.idx  = psrl_pkg::IDX_W'(IDX);
      end
      if (cmd.add && (cmd.idx == psrl_pkg::IDX_W'(IDX))) begin
         valid_in = 1'b1;
         addr_in  = query_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         link_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         link_ff  <= link_in;
      end
      addr_ff <= addr_in;
   end

   assign link_o = link_ff;

endmodule

[hw/rtl/psrl_cnt_cell.sv]
// -----------------------------------------------------------------------------
// Counter cell
// Holds one per-source counter; counts a matching word and reports free slots.
// -----------------------------------------------------------------------------
module psrl_cnt_cell #(
   parameter int IDX = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [31:0]            query_addr,
   input  psrl_pkg::cnt_cmd_type  cmd,
   input  psrl_pkg::cnt_link_type link_i,
   output psrl_pkg::cnt_link_type link_o
);

   logic                   valid_ff, valid_in;
   logic [31:0]            addr_ff, addr_in;
   logic [15:0]            value_ff, value_in;
   psrl_pkg::cnt_link_type link_ff, link_in;

   always_comb begin
      link_in  = link_i;
      valid_in = valid_ff;
      addr_in  = addr_ff;
      value_in = value_ff;
      if (link_i.tok && valid_ff && (addr_ff == query_addr)) begin
         link_in.hit = 1'b1;
         link_in.old = value_ff;
         if (value_ff != psrl_pkg::COUNT_MAX) begin
            value_in = value_ff + 16'd1;
         end
      end
      if (link_i.tok && !link_i.free && !valid_ff) begin
         link_in.free = 1'b1;
         link_in.idx  = psrl_pkg::IDX_W'(IDX);
      end
      if (cmd.clear) begin
         valid_in = 1'b0;
      end
      if (cmd.alloc && (cmd.idx == psrl_pkg::IDX_W'(IDX))) begin
         // A new source starts at zero and has just been counted once.
         valid_in = 1'b1;
         addr_in  = query_addr;
         value_in = 16'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         link_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         link_ff  <= link_in;
      end
      addr_ff  <= addr_in;
      value_ff <= value_in;
   end

   assign link_o = link_ff;

endmodule

[hw/rtl/per_source_rate_limiter.sv]
// -----------------------------------------------------------------------------
// Per-source rate limiter
// Fixed-window message limiter with a per-source counter chain and a ban chain.
// -----------------------------------------------------------------------------
// A banned source gets its verdict word after the walk along the ban chain,
// any other source after the walk along the ban chain and then the counter
// chain, one cell per cycle. One word is in flight at a time, so a new word
// can be taken from the cycle after the last verdict is loaded. Reset is
// synchronous and active high: it empties both tables, zeroes the clear time
// and restores register defaults.
// -----------------------------------------------------------------------------
module per_source_rate_limiter #(
   parameter int RATE_ENTRIES = psrl_pkg::RATE_ENTRIES_DEF,
   parameter int BAN_ENTRIES  = psrl_pkg::BAN_ENTRIES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   psrl_req_if.sink                        req_bus,
   psrl_rsp_if.source                      rsp_bus,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [psrl_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [psrl_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [psrl_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);

   // Configuration registers. The word address selects the register; the
   // byte offset bits are ignored.
   logic [15:0] max_per_window_ff;
   logic [11:0] window_seconds_ff;
   logic [15:0] log_threshold_ff;
   logic [31:0] exempt_addr_ff;

   psrl_pkg::reg_index_type csr_index;
   logic                    csr_write;

   assign csr_pready = 1'b1;
   assign csr_index  = psrl_pkg::reg_index_type'(csr_paddr[3:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_per_window_ff <= psrl_pkg::MAX_PER_WINDOW_RST;
         window_seconds_ff <= psrl_pkg::WINDOW_SECONDS_RST;
         log_threshold_ff  <= psrl_pkg::LOG_THRESHOLD_RST;
         exempt_addr_ff    <= psrl_pkg::EXEMPT_ADDR_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            psrl_pkg::REG_MAX_PER_WINDOW: max_per_window_ff <= csr_pwdata[15:0];
            psrl_pkg::REG_WINDOW_SECONDS: window_seconds_ff <= csr_pwdata[11:0];
            psrl_pkg::REG_LOG_THRESHOLD:  log_threshold_ff  <= csr_pwdata[15:0];
            psrl_pkg::REG_EXEMPT_ADDR:    exempt_addr_ff    <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         psrl_pkg::REG_MAX_PER_WINDOW: csr_prdata = {16'd0, max_per_window_ff};
         psrl_pkg::REG_WINDOW_SECONDS: csr_prdata = {20'd0, window_seconds_ff};
         psrl_pkg::REG_LOG_THRESHOLD:  csr_prdata = {16'd0, log_threshold_ff};
         psrl_pkg::REG_EXEMPT_ADDR:    csr_prdata = exempt_addr_ff;
         default:                      csr_prdata = '0;
      endcase
   end

   // Sequencer state and the word being processed.
   psrl_pkg::state_type state_ff, state_in;
   logic [31:0]         src_ff, src_in;
   logic [31:0]         now_ff, now_in;
   logic [31:0]         last_clear_ff, last_clear_in;
   logic                ban_free_ff, ban_free_in;
   logic [psrl_pkg::IDX_W-1:0] ban_idx_ff, ban_idx_in;

   // Verdict waiting for the output register.
   logic [2:0]          res_verdict_ff, res_verdict_in;
   logic                res_flag_ff, res_flag_in;
   logic [15:0]         res_count_ff, res_count_in;

   // Output register.
   logic                rsp_valid_ff, rsp_valid_in;
   logic [2:0]          rsp_verdict_ff, rsp_verdict_in;
   logic                rsp_flag_ff, rsp_flag_in;
   logic [15:0]         rsp_count_ff, rsp_count_in;

   // Chains of cells. Link k feeds cell k; the last link returns to the sequencer.
   psrl_pkg::ban_link_type ban_link [BAN_ENTRIES+1];
   psrl_pkg::cnt_link_type cnt_link [RATE_ENTRIES+1];
   psrl_pkg::ban_cmd_type  ban_cmd;
   psrl_pkg::cnt_cmd_type  cnt_cmd;
   logic [31:0]            ban_query;

   logic                   req_take;
   logic                   out_free;
   psrl_pkg::ban_link_type ban_done;
   psrl_pkg::cnt_link_type cnt_done;
   logic [31:0]            elapsed;
   logic [15:0]            old_count;
   logic [15:0]            new_count;

   assign req_bus.ready = (state_ff == psrl_pkg::ST_IDLE);
   assign req_take      = req_bus.valid && req_bus.ready;
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;
   assign ban_done      = ban_link[BAN_ENTRIES];
   assign cnt_done      = cnt_link[RATE_ENTRIES];

   // The ban walk starts in the cycle the word is taken, so the first cell
   // sees the address straight from the channel.
   assign ban_query = (state_ff == psrl_pkg::ST_IDLE) ? req_bus.src_addr : src_ff;

   always_comb begin
      ban_link[0]     = '0;
      ban_link[0].tok = req_take;
      cnt_link[0]     = '0;
      cnt_link[0].tok = (state_ff == psrl_pkg::ST_CSTART);
   end

   for (genvar g = 0; g < BAN_ENTRIES; g++) begin : g_ban
      psrl_ban_cell #(
         .IDX (g)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .query_addr (ban_query),
         .cmd        (ban_cmd),
         .link_i     (ban_link[g]),
         .link_o     (ban_link[g+1])
      );
   end

   for (genvar g = 0; g < RATE_ENTRIES; g++) begin : g_cnt
      psrl_cnt_cell #(
         .IDX (g)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .query_addr (src_ff),
         .cmd        (cnt_cmd),
         .link_i     (cnt_link[g]),
         .link_o     (cnt_link[g+1])
      );
   end

   // Time since the last clear, modulo 2^32, and the count arithmetic for
   // the word coming off the end of the counter chain. A source that was not
   // found is counted from zero in the slot the chain reported as free.
   assign elapsed   = now_ff - last_clear_ff;
   assign old_count = cnt_done.hit ? cnt_done.old : 16'd0;
   assign new_count = (old_count == psrl_pkg::COUNT_MAX) ? old_count : old_count + 16'd1;

   always_comb begin
      state_in       = state_ff;
      src_in         = src_ff;
      now_in         = now_ff;
      last_clear_in  = last_clear_ff;
      ban_free_in    = ban_free_ff;
      ban_idx_in     = ban_idx_ff;
      res_verdict_in = res_verdict_ff;
      res_flag_in    = res_flag_ff;
      res_count_in   = res_count_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_bus.ready;
      rsp_verdict_in = rsp_verdict_ff;
      rsp_flag_in    = rsp_flag_ff;
      rsp_count_in   = rsp_count_ff;
      ban_cmd        = '0;
      cnt_cmd        = '0;

      unique case (state_ff)
         psrl_pkg::ST_IDLE: begin
            if (req_take) begin
               src_in   = req_bus.src_addr;
               now_in   = req_bus.now_seconds;
               state_in = psrl_pkg::ST_BAN;
            end
         end

         psrl_pkg::ST_BAN: begin
            if (ban_done.tok) begin
               ban_free_in = ban_done.free;
               ban_idx_in  = ban_done.idx;
               if (ban_done.hit) begin
                  // Banned sources leave counters and the window untouched.
                  res_verdict_in = psrl_pkg::VERDICT_DROPPED;
                  res_flag_in    = 1'b0;
                  res_count_in   = 16'd0;
                  state_in       = psrl_pkg::ST_FIN;
               end else begin
                  if (elapsed > {20'd0, window_seconds_ff}) begin
                     cnt_cmd.clear = 1'b1;
                     last_clear_in = now_ff;
                  end
                  state_in = psrl_pkg::ST_CSTART;
               end
            end
         end

         psrl_pkg::ST_CSTART: begin
            state_in = psrl_pkg::ST_CNT;
         end

         psrl_pkg::ST_CNT: begin
            if (cnt_done.tok) begin
               state_in = psrl_pkg::ST_FIN;
               if (!cnt_done.hit && !cnt_done.free) begin
                  // No slot for this source: refused, but not banned.
                  res_verdict_in = psrl_pkg::VERDICT_TABFULL;
                  res_flag_in    = 1'b0;
                  res_count_in   = 16'd0;
               end else begin
                  if (!cnt_done.hit) begin
                     cnt_cmd.alloc = 1'b1;
                     cnt_cmd.idx   = cnt_done.idx;
                  end
                  res_flag_in  = (new_count > log_threshold_ff);
                  res_count_in = new_count;
                  if ((old_count < max_per_window_ff) || (src_ff == exempt_addr_ff)) begin
                     res_verdict_in = psrl_pkg::VERDICT_ACCEPT;
                  end else if (ban_free_ff) begin
                     ban_cmd.add    = 1'b1;
                     ban_cmd.idx    = ban_idx_ff;
                     res_verdict_in = psrl_pkg::VERDICT_NEWBAN;
                  end else begin
                     res_verdict_in = psrl_pkg::VERDICT_BANFULL;
                  end
               end
            end
         end

         psrl_pkg::ST_FIN: begin
            // Wait for the output register to drain before taking a new word.
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_verdict_in = res_verdict_ff;
               rsp_flag_in    = res_flag_ff;
               rsp_count_in   = res_count_ff;
               state_in       = psrl_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = psrl_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= psrl_pkg::ST_IDLE;
         last_clear_ff <= 32'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         last_clear_ff <= last_clear_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      src_ff         <= src_in;
      now_ff         <= now_in;
      ban_free_ff    <= ban_free_in;
      ban_idx_ff     <= ban_idx_in;
      res_verdict_ff <= res_verdict_in;
      res_flag_ff    <= res_flag_in;
      res_count_ff   <= res_count_in;
      rsp_verdict_ff <= rsp_verdict_in;
      rsp_flag_ff    <= rsp_flag_in;
      rsp_count_ff   <= rsp_count_in;
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.verdict      = rsp_verdict_ff;
   assign rsp_bus.detail_flag  = rsp_flag_ff;
   assign rsp_bus.source_count = rsp_count_ff;

endmodule
